>>> rtl/per_worker_reduction_accumulator_unit_assert.svh
// Assertion macros shared by the accumulator modules.
`ifndef PER_WORKER_REDUCTION_ACCUMULATOR_UNIT_ASSERT_SVH
`define PER_WORKER_REDUCTION_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PWRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PWRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PWRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/pwra_pkg.sv
`timescale 1ns / 1ps

package pwra_pkg;

    localparam int WORKERS  = 16;
    localparam int WORKER_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int OP_W     = 2;
    localparam int ROP_W    = 4;
    localparam int ACT_W    = 5;

    // Item op codes
    localparam logic [OP_W-1:0] OPC_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OPC_OPEN  = 2'd1;
    localparam logic [OP_W-1:0] OPC_CLOSE = 2'd2;

    // Reduction codes
    localparam logic [ROP_W-1:0] ROP_MAX  = 4'd0;
    localparam logic [ROP_W-1:0] ROP_MIN  = 4'd1;
    localparam logic [ROP_W-1:0] ROP_ADD  = 4'd2;
    localparam logic [ROP_W-1:0] ROP_MUL  = 4'd3;
    localparam logic [ROP_W-1:0] ROP_LAND = 4'd4;
    localparam logic [ROP_W-1:0] ROP_BAND = 4'd5;
    localparam logic [ROP_W-1:0] ROP_LOR  = 4'd6;
    localparam logic [ROP_W-1:0] ROP_BOR  = 4'd7;
    localparam logic [ROP_W-1:0] ROP_LXOR = 4'd8;
    localparam logic [ROP_W-1:0] ROP_BXOR = 4'd9;

    // Register indexes
    localparam logic REG_REDUCE_OP      = 1'b0;
    localparam logic REG_ACTIVE_WORKERS = 1'b1;

    localparam logic [ROP_W-1:0] REDUCE_OP_RST      = ROP_ADD;
    localparam logic [ACT_W-1:0] ACTIVE_WORKERS_RST = 5'd16;

    typedef enum logic [2:0] {
        K_PUT,
        K_REJECT,
        K_OPEN,
        K_CLOSE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [WORKER_W-1:0]        worker;
        logic signed [DATA_W-1:0]   value;
    } t_cmd;

    // Every reduction but multiply, in one step.
    function automatic logic [DATA_W-1:0] fold_simple(
        input logic [ROP_W-1:0]  rop,
        input logic [DATA_W-1:0] cur,
        input logic [DATA_W-1:0] nv
    );
        logic cur_t;
        logic nv_t;
        logic [DATA_W-1:0] res;
        cur_t = (cur != '0);
        nv_t  = (nv != '0);
        case (rop)
            ROP_MAX:  res = ($signed(cur) < $signed(nv)) ? nv : cur;
            ROP_MIN:  res = ($signed(nv) < $signed(cur)) ? nv : cur;
            ROP_ADD:  res = cur + nv;
            ROP_LAND: res = DATA_W'(cur_t & nv_t);
            ROP_BAND: res = cur & nv;
            ROP_LOR:  res = DATA_W'(cur_t | nv_t);
            ROP_BOR:  res = cur | nv;
            ROP_LXOR: res = DATA_W'(cur_t ^ nv_t);
            ROP_BXOR: res = cur ^ nv;
            default:  res = cur;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/pwra_front.sv
`timescale 1ns / 1ps
`include "per_worker_reduction_accumulator_unit_assert.svh"

module pwra_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [pwra_pkg::OP_W-1:0]     i_op,
    input  logic [pwra_pkg::WORKER_W-1:0] i_worker,
    input  logic [pwra_pkg::DATA_W-1:0]   i_value,
    input  logic [pwra_pkg::ACT_W-1:0]    i_act_cnt,
    output logic                          o_cmd_valid,
    output pwra_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    import pwra_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       cls;
    logic       push_ok;
    logic       pop_ok;

    // Classify on the way in
    always_comb begin
        cls.worker = i_worker;
        cls.value  = i_value;
        case (i_op)
            OPC_PUT:   cls.kind = (ACT_W'(i_worker) < i_act_cnt) ? K_PUT : K_REJECT;
            OPC_OPEN:  cls.kind = K_OPEN;
            OPC_CLOSE: cls.kind = K_CLOSE;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `PWRA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_count <= 2'd2),
        "command queue count out of range")
    `PWRA_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, push_ok, (r_count != 2'd0),
        "accepted item missing from command queue")
    `PWRA_ASSERT_IMP(a_ptr_empty, i_clk, i_rst_n, (r_count == 2'd0),
        (r_wr_ptr == r_rd_ptr), "queue pointers differ while empty")

endmodule

>>> rtl/pwra_fold.sv
`timescale 1ns / 1ps

module pwra_fold (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pwra_pkg::ROP_W-1:0]   i_rop,
    input  logic [pwra_pkg::DATA_W-1:0]  i_a,
    input  logic [pwra_pkg::DATA_W-1:0]  i_b,
    output logic                         o_done,
    output logic [pwra_pkg::DATA_W-1:0]  o_result
);
    import pwra_pkg::*;

    // Operands are held by the caller until done.
    logic [DATA_W-1:0] r_res;
    logic              r_busy;
    logic [1:0]        r_step;
    logic              r_done;
    logic              n_done;
    logic [1:0]        step;
    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    logic [DATA_W-1:0] prod;

    assign step = i_start ? 2'd0 : r_step;

    // One shared 32x32 multiplier: lo*lo, then the two cross terms
    always_comb begin
        case (step)
            2'd1: begin
                mul_x = i_a[HALF_W-1:0];
                mul_y = i_b[DATA_W-1:HALF_W];
            end
            2'd2: begin
                mul_x = i_a[DATA_W-1:HALF_W];
                mul_y = i_b[HALF_W-1:0];
            end
            default: begin
                mul_x = i_a[HALF_W-1:0];
                mul_y = i_b[HALF_W-1:0];
            end
        endcase
    end

    assign prod = DATA_W'(mul_x) * DATA_W'(mul_y);

    // Single-step reductions finish at once, multiply after its last cross term
    assign n_done = (i_start && (i_rop != ROP_MUL)) || (!i_start && r_busy && (r_step == 2'd2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_start) begin
                if (i_rop == ROP_MUL) begin
                    r_res  <= prod;
                    r_busy <= 1'b1;
                    r_step <= 2'd1;
                end else begin
                    r_res  <= fold_simple(i_rop, i_a, i_b);
                end
            end else if (r_busy) begin
                r_res[DATA_W-1:HALF_W] <= r_res[DATA_W-1:HALF_W] + prod[HALF_W-1:0];
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_step <= 2'd0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> rtl/pwra_back.sv
`timescale 1ns / 1ps
`include "per_worker_reduction_accumulator_unit_assert.svh"

module pwra_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pwra_pkg::ROP_W-1:0]  i_rop,
    input  logic [pwra_pkg::ACT_W-1:0]  i_act_cnt,
    input  logic                        i_cmd_valid,
    input  pwra_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [pwra_pkg::DATA_W-1:0] o_total_value,
    output logic [pwra_pkg::DATA_W-1:0] o_slot_value,
    output logic                        o_worker_error
);
    import pwra_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PUT,
        B_OPEN,
        B_CLOSE,
        B_EMIT
    } t_bstate;

    t_bstate             r_state;
    t_cmd                r_cmd;
    logic [DATA_W-1:0]   r_slots [WORKERS];
    logic [DATA_W-1:0]   r_total;
    logic [DATA_W-1:0]   r_slot_res;
    logic                r_err;
    logic [WORKER_W-1:0] r_idx;
    logic                r_fold_start;
    logic [DATA_W-1:0]   r_fa;
    logic [DATA_W-1:0]   r_fb;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_total;
    logic [DATA_W-1:0]   r_out_slot;
    logic                r_out_err;

    logic                fold_done;
    logic [DATA_W-1:0]   fold_res;
    logic [WORKER_W-1:0] rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic [ACT_W-1:0]    last_idx;
    logic                at_last;
    logic                take;
    logic                out_load;
    logic                n_fold_start;
    logic                n_out_valid;

    pwra_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_fold_start),
        .i_rop    (i_rop),
        .i_a      (r_fa),
        .i_b      (r_fb),
        .o_done   (fold_done),
        .o_result (fold_res)
    );

    // Single slot read port: the put target, slot zero to begin a close, else the next slot
    always_comb begin
        if (r_state == B_IDLE) begin
            rd_addr = (i_cmd.kind == K_PUT) ? i_cmd.worker : '0;
        end else begin
            rd_addr = r_idx + WORKER_W'(1);
        end
    end

    assign rd_data   = r_slots[rd_addr];
    assign last_idx  = i_act_cnt - ACT_W'(1);
    assign at_last   = (ACT_W'(r_idx) == last_idx);
    assign take      = (r_state == B_IDLE) && i_cmd_valid;
    assign o_cmd_pop = take;

    // Hold the result until the result register is free or being drained
    assign out_load     = (r_state == B_EMIT) && (!r_out_valid || i_pop);
    assign n_out_valid  = out_load || (r_out_valid && !i_pop);
    assign n_fold_start = (take && ((i_cmd.kind == K_PUT) ||
                                    ((i_cmd.kind == K_CLOSE) && (i_act_cnt != '0)))) ||
                          ((r_state == B_CLOSE) && fold_done && !at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_total      <= '0;
            r_fold_start <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            for (int i = 0; i < WORKERS; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            r_fold_start <= n_fold_start;
            r_out_valid  <= n_out_valid;
            case (r_state)
                B_IDLE: begin
                    if (take) begin
                        r_cmd      <= i_cmd;
                        r_slot_res <= '0;
                        r_err      <= 1'b0;
                        r_idx      <= '0;
                        case (i_cmd.kind)
                            K_PUT: begin
                                r_fa    <= rd_data;
                                r_fb    <= i_cmd.value;
                                r_state <= B_PUT;
                            end
                            K_REJECT: begin
                                r_err   <= 1'b1;
                                r_state <= B_EMIT;
                            end
                            K_OPEN: begin
                                r_total <= i_cmd.value;
                                r_state <= (i_act_cnt == '0) ? B_EMIT : B_OPEN;
                            end
                            K_CLOSE: begin
                                if (i_act_cnt == '0) begin
                                    r_state <= B_EMIT;
                                end else begin
                                    r_fa    <= r_total;
                                    r_fb    <= rd_data;
                                    r_state <= B_CLOSE;
                                end
                            end
                            default: r_state <= B_EMIT;
                        endcase
                    end
                end
                B_PUT: begin
                    if (fold_done) begin
                        r_slots[r_cmd.worker] <= fold_res;
                        r_slot_res            <= fold_res;
                        r_state               <= B_EMIT;
                    end
                end
                B_OPEN: begin
                    r_slots[r_idx] <= r_cmd.value;
                    if (at_last) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_idx <= r_idx + WORKER_W'(1);
                    end
                end
                B_CLOSE: begin
                    if (fold_done) begin
                        r_total <= fold_res;
                        if (at_last) begin
                            r_state <= B_EMIT;
                        end else begin
                            r_idx <= r_idx + WORKER_W'(1);
                            r_fa  <= fold_res;
                            r_fb  <= rd_data;
                        end
                    end
                end
                B_EMIT: begin
                    if (out_load) begin
                        r_out_total <= r_total;
                        r_out_slot  <= r_slot_res;
                        r_out_err   <= r_err;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_total_value  = r_out_total;
    assign o_slot_value   = r_out_slot;
    assign o_worker_error = r_out_err;

    `PWRA_ASSERT_IMP(a_done_state, i_clk, i_rst_n, fold_done,
        ((r_state == B_PUT) || (r_state == B_CLOSE)), "fold result with no fold pending")
    `PWRA_ASSERT_IMP(a_idx_range, i_clk, i_rst_n,
        ((r_state == B_OPEN) || (r_state == B_CLOSE)), (ACT_W'(r_idx) < i_act_cnt),
        "sweep index past active count")
    `PWRA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_pop),
        (r_out_valid && $stable(r_out_total) && $stable(r_out_slot) && $stable(r_out_err)),
        "waiting result changed before pop")

endmodule

>>> rtl/per_worker_reduction_accumulator_unit.sv
`timescale 1ns / 1ps
// Per-worker reduction accumulator: one 64-bit total plus one 64-bit partial per worker.
// Input channel: push/full carries op, worker and value; an item enters when push is high
// and full is low. A two-entry command queue sits behind the input, so the block keeps
// taking items while earlier ones are still being worked on.
// Result channel: empty/pop; every item gives exactly one result, in order, held on the
// result ports while empty is low and taken when pop is high.
// Configuration: APB port, reduce_op at byte 0 and active_workers at byte 4; write only
// while the block is idle.
// The slot sequencer works on one item at a time, using the fold unit and its shared
// 32x32 multiplier for multiply; the back end takes the next item the cycle after a result
// is loaded. Put folds the value into its slot; a rejected put, an unknown op, or an
// open or close with no active slots goes straight to the result; open loads the total
// and then each active slot in turn; close folds each active slot into the total in turn.
// Reset clears the total, all slots and the queues and loads reduce_op = add and
// active_workers = 16. A stalled receiver holds the result; the back end then waits with
// the next result, and once the command queue is full, full rises.
module per_worker_reduction_accumulator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [pwra_pkg::OP_W-1:0]     i_op,
    input  logic [pwra_pkg::WORKER_W-1:0] i_worker,
    input  logic signed [pwra_pkg::DATA_W-1:0] i_value,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [pwra_pkg::DATA_W-1:0] o_total_value,
    output logic signed [pwra_pkg::DATA_W-1:0] o_slot_value,
    output logic                          o_worker_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pwra_pkg::*;

    logic [ROP_W-1:0]  r_reduce_op;
    logic [ACT_W-1:0]  r_active_workers;
    logic [ACT_W-1:0]  act_cnt;
    logic              cfg_wr;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              cmd_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_op      <= REDUCE_OP_RST;
            r_active_workers <= ACTIVE_WORKERS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_REDUCE_OP:      r_reduce_op      <= pwdata[ROP_W-1:0];
                REG_ACTIVE_WORKERS: r_active_workers <= pwdata[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_REDUCE_OP:      prdata = 32'(r_reduce_op);
            REG_ACTIVE_WORKERS: prdata = 32'(r_active_workers);
            default:            prdata = '0;
        endcase
    end

    // Saturate the active count to the number of slots
    assign act_cnt = (r_active_workers > ACT_W'(WORKERS)) ? ACT_W'(WORKERS) : r_active_workers;

    pwra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_worker    (i_worker),
        .i_value     (i_value),
        .i_act_cnt   (act_cnt),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pwra_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rop          (r_reduce_op),
        .i_act_cnt      (act_cnt),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_total_value  (o_total_value),
        .o_slot_value   (o_slot_value),
        .o_worker_error (o_worker_error)
    );

endmodule

>>> verif/per_worker_reduction_accumulator_unit_test.sv
`timescale 1ns / 1ps

module per_worker_reduction_accumulator_unit_test;
    import pwra_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_AFTER    = 400;

    localparam logic [OP_W-1:0]   OPC_SPARE = 2'd3;
    localparam logic [ROP_W-1:0]  ROP_SPARE = 4'd12;
    localparam logic [DATA_W-1:0] V_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] V_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] V_ONES    = '1;

    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] slot;
        logic              err;
    } t_acc_result;

    typedef enum logic [1:0] {ROW_CFG, ROW_FREE, ROW_FIXED} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [ROP_W-1:0]    rop;
        logic [ACT_W-1:0]    act;
        logic [OP_W-1:0]     op;
        logic [WORKER_W-1:0] worker;
        logic [DATA_W-1:0]   value;
        t_acc_result         res;
    } t_step_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic [OP_W-1:0]            i_op;
    logic [WORKER_W-1:0]        i_worker;
    logic signed [DATA_W-1:0]   i_value;
    logic                       empty;
    logic                       pop;
    logic signed [DATA_W-1:0]   o_total_value;
    logic signed [DATA_W-1:0]   o_slot_value;
    logic                       o_worker_error;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    per_worker_reduction_accumulator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_worker       (i_worker),
        .i_value        (i_value),
        .empty          (empty),
        .pop            (pop),
        .o_total_value  (o_total_value),
        .o_slot_value   (o_slot_value),
        .o_worker_error (o_worker_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // shadow of the accumulator state
    logic [DATA_W-1:0] acc_total;
    logic [DATA_W-1:0] acc_slot [WORKERS];
    logic [ROP_W-1:0]  cfg_rop;
    logic [ACT_W-1:0]  cfg_active;

    t_acc_result pending_results [$];
    t_step_row   dir_rows [$];

    int fail_count    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int full_stalls   = 0;
    int calm_left     = 0;
    int cycle_count   = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] reduce_pair(input logic [ROP_W-1:0] rop,
                                                      input logic [DATA_W-1:0] acc,
                                                      input logic [DATA_W-1:0] nv);
        logic acc_t;
        logic nv_t;
        logic [DATA_W-1:0] r;
        acc_t = |acc;
        nv_t  = |nv;
        case (rop)
            ROP_MAX:  r = ($signed(acc) < $signed(nv)) ? nv : acc;
            ROP_MIN:  r = ($signed(nv) < $signed(acc)) ? nv : acc;
            ROP_ADD:  r = acc + nv;
            ROP_MUL:  r = acc * nv;
            ROP_LAND: r = {{(DATA_W-1){1'b0}}, acc_t & nv_t};
            ROP_BAND: r = acc & nv;
            ROP_LOR:  r = {{(DATA_W-1){1'b0}}, acc_t | nv_t};
            ROP_BOR:  r = acc | nv;
            ROP_LXOR: r = {{(DATA_W-1){1'b0}}, acc_t ^ nv_t};
            ROP_BXOR: r = acc ^ nv;
            default:  r = acc;
        endcase
        return r;
    endfunction

    function automatic int effective_count(input logic [ACT_W-1:0] act);
        return (act > ACT_W'(WORKERS)) ? WORKERS : int'(act);
    endfunction

    task automatic apply_item(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wk,
                              input logic [DATA_W-1:0] val, output t_acc_result res);
        int n;
        n   = effective_count(cfg_active);
        res = '0;
        case (op)
            OPC_PUT: begin
                if (int'(wk) < n) begin
                    acc_slot[wk] = reduce_pair(cfg_rop, acc_slot[wk], val);
                    res.slot     = acc_slot[wk];
                end else begin
                    res.err = 1'b1;
                end
            end
            OPC_OPEN: begin
                acc_total = val;
                for (int i = 0; i < n; i++) acc_slot[i] = val;
            end
            OPC_CLOSE: begin
                for (int i = 0; i < n; i++)
                    acc_total = reduce_pair(cfg_rop, acc_total, acc_slot[i]);
            end
            default: ;
        endcase
        res.total = acc_total;
    endtask

    function automatic t_acc_result outcome(input logic [DATA_W-1:0] t,
                                            input logic [DATA_W-1:0] s, input logic e);
        t_acc_result r;
        r.total = t;
        r.slot  = s;
        r.err   = e;
        return r;
    endfunction

    task automatic cfg_row(input logic [ROP_W-1:0] rop, input logic [ACT_W-1:0] act);
        t_step_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.rop  = rop;
        r.act  = act;
        dir_rows.push_back(r);
    endtask

    task automatic item_row(input bit fixed, input logic [OP_W-1:0] op,
                            input logic [WORKER_W-1:0] wk, input logic [DATA_W-1:0] val,
                            input t_acc_result res);
        t_step_row r;
        r        = '0;
        r.kind   = fixed ? ROW_FIXED : ROW_FREE;
        r.op     = op;
        r.worker = wk;
        r.value  = val;
        r.res    = res;
        dir_rows.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 2) begin
            calm_left = int'($urandom_range(30, 80));
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DATA_W'($urandom_range(1, 7));
            2: return -DATA_W'($urandom_range(1, 7));
            3: begin
                case ($urandom_range(0, 3))
                    0: return V_MIN;
                    1: return V_MAX;
                    2: return V_ONES;
                    default: return DATA_W'(1);
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORKER_W-1:0] pick_worker(input int n);
        if (n > 0 && $urandom_range(0, 7) != 0)
            return WORKER_W'($urandom_range(0, n - 1));
        return WORKER_W'($urandom_range(0, WORKERS - 1));
    endfunction

    task automatic offer_item(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wk,
                              input logic [DATA_W-1:0] val, input bit fixed,
                              input t_acc_result fixed_res);
        t_acc_result predicted;
        int gap;
        push     <= 1'b1;
        i_op     <= op;
        i_worker <= wk;
        i_value  <= val;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        apply_item(op, wk, val, predicted);
        pending_results.push_back(fixed ? fixed_res : predicted);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic reg_access(input logic idx, input bit wr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ROP_W-1:0] rop, input logic [ACT_W-1:0] act);
        logic [31:0] rd;
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let the back end settle before touching the registers
        repeat (4) @(posedge i_clk);
        reg_access(REG_REDUCE_OP, 1'b1, 32'(rop), rd);
        reg_access(REG_ACTIVE_WORKERS, 1'b1, 32'(act), rd);
        reg_access(REG_REDUCE_OP, 1'b0, '0, rd);
        if (rd !== 32'(rop)) flag_mismatch("reduce_op readback", 64'(rop), 64'(rd));
        reg_access(REG_ACTIVE_WORKERS, 1'b0, '0, rd);
        if (rd !== 32'(act)) flag_mismatch("active_workers readback", 64'(act), 64'(rd));
        cfg_rop    = rop;
        cfg_active = act;
        settings_used++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_acc_result want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, o_total_value);
            end else begin
                want = pending_results.pop_front();
                if (o_total_value !== want.total)
                    flag_mismatch("total_value", want.total, o_total_value);
                if (o_slot_value !== want.slot)
                    flag_mismatch("slot_value", want.slot, o_slot_value);
                if (o_worker_error !== want.err)
                    flag_mismatch("worker_error", 64'(want.err), 64'(o_worker_error));
            end
        end
    end

    initial begin : result_sink
        int hold;
        int quiet;
        int taken;
        int r;
        bit long_done;
        hold      = 0;
        quiet     = 0;
        taken     = 0;
        long_done = 1'b0;
        pop       = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pop && !empty) taken++;
            if (!long_done && taken >= HOLD_AFTER) begin
                // stop taking results so the input side backs up
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end else if (hold == 0 && quiet == 0) begin
                r = int'($urandom_range(0, 99));
                if (r < 20)      hold  = int'($urandom_range(1, 3));
                else if (r < 23) hold  = int'($urandom_range(20, 60));
                else if (r < 26) quiet = int'($urandom_range(40, 150));
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                if (quiet > 0) quiet--;
                pop <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_step_row         row;
        logic [ROP_W-1:0]  rop;
        logic [ACT_W-1:0]  act;
        int                directed_items;
        int                phase;
        int                stop_at;
        int                n;

        i_rst_n  = 1'b0;
        push     = 1'b0;
        i_op     = '0;
        i_worker = '0;
        i_value  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        acc_total = '0;
        foreach (acc_slot[i]) acc_slot[i] = '0;
        cfg_rop    = REDUCE_OP_RST;
        cfg_active = ACTIVE_WORKERS_RST;

        // after reset: add over sixteen zeroed slots
        item_row(1'b1, OPC_PUT, 4'd0, 64'd5, outcome('0, 64'd5, 1'b0));
        item_row(1'b1, OPC_PUT, 4'd15, V_ONES, outcome('0, V_ONES, 1'b0));
        item_row(1'b1, OPC_CLOSE, 4'd0, '0, outcome(64'd4, '0, 1'b0));
        // unknown op code only reports the total
        item_row(1'b1, OPC_SPARE, 4'd0, 64'd123, outcome(64'd4, '0, 1'b0));
        item_row(1'b1, OPC_OPEN, 4'd0, V_MIN, outcome(V_MIN, '0, 1'b0));
        item_row(1'b1, OPC_PUT, 4'd3, V_MAX, outcome(V_MIN, V_ONES, 1'b0));
        cfg_row(ROP_MAX, 5'd1);
        item_row(1'b1, OPC_PUT, 4'd1, '0, outcome(V_MIN, '0, 1'b1));
        item_row(1'b0, OPC_PUT, 4'd0, V_MAX, '0);
        item_row(1'b0, OPC_CLOSE, 4'd0, '0, '0);
        cfg_row(ROP_MIN, 5'd16);
        item_row(1'b0, OPC_PUT, 4'd9, V_MIN, '0);
        item_row(1'b0, OPC_PUT, 4'd9, V_MAX, '0);
        cfg_row(ROP_MUL, 5'd16);
        item_row(1'b0, OPC_OPEN, 4'd0, 64'd3, '0);
        item_row(1'b0, OPC_PUT, 4'd7, 64'hffff_ffff_ffff_fffe, '0);
        item_row(1'b0, OPC_CLOSE, 4'd0, '0, '0);
        // undefined reduction holds every slot; a count above sixteen saturates
        cfg_row(ROP_SPARE, 5'd20);
        item_row(1'b0, OPC_PUT, 4'd15, 64'd77, '0);
        item_row(1'b0, OPC_CLOSE, 4'd0, '0, '0);
        // no active slots: open loads the total only, every put is rejected
        cfg_row(ROP_LXOR, 5'd0);
        item_row(1'b1, OPC_OPEN, 4'd0, 64'd9, outcome(64'd9, '0, 1'b0));
        item_row(1'b1, OPC_PUT, 4'd0, 64'd1, outcome(64'd9, '0, 1'b1));
        item_row(1'b1, OPC_CLOSE, 4'd0, '0, outcome(64'd9, '0, 1'b0));
        cfg_row(ROP_BXOR, 5'd16);
        item_row(1'b0, OPC_PUT, 4'd5, 64'haaaa_aaaa_aaaa_aaaa, '0);
        item_row(1'b0, OPC_PUT, 4'd5, 64'h5555_5555_5555_5555, '0);
        item_row(1'b0, OPC_CLOSE, 4'd0, '0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            case (row.kind)
                ROW_CFG:   set_config(row.rop, row.act);
                ROW_FIXED: offer_item(row.op, row.worker, row.value, 1'b1, row.res);
                default:   offer_item(row.op, row.worker, row.value, 1'b0, '0);
            endcase
        end
        directed_items = items_sent;

        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            if (phase <= int'(ROP_BXOR))
                rop = ROP_W'(phase);
            else if ($urandom_range(0, 3) == 0)
                rop = ROP_W'($urandom_range(int'(ROP_BXOR) + 1, 15));
            else
                rop = ROP_W'($urandom_range(0, int'(ROP_BXOR)));
            case (phase % 6)
                0:       act = ACT_W'(WORKERS);
                1:       act = 5'd1;
                2:       act = 5'd0;
                3:       act = 5'd31;
                default: act = ACT_W'($urandom_range(1, WORKERS));
            endcase
            set_config(rop, act);
            n       = effective_count(act);
            stop_at = items_sent + int'($urandom_range(20, 50));
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray item: any op, any worker
                    offer_item(OP_W'($urandom_range(0, 3)), WORKER_W'($urandom_range(0, 15)),
                               pick_value(), 1'b0, '0);
                end else begin
                    if ($urandom_range(0, 4) != 0)
                        offer_item(OPC_OPEN, WORKER_W'($urandom_range(0, 15)), pick_value(),
                                   1'b0, '0);
                    repeat ($urandom_range(1, 12))
                        offer_item(OPC_PUT, pick_worker(n), pick_value(), 1'b0, '0);
                    offer_item(OPC_CLOSE, WORKER_W'($urandom_range(0, 15)), pick_value(),
                               1'b0, '0);
                end
            end
            phase++;
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d items (%0d directed) under %0d register settings, %0d results compared",
                 items_sent, directed_items, settings_used, results_seen);
        $display("Input held off by full on %0d cycles; %0d mismatches counted",
                 full_stalls, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
